/* rtl/core/cnps_pkg.sv */
// Package for the CSR neighbor partition splitter: payload types and codes.
// No dependencies.
`timescale 1ns / 1ps
package cnps_pkg;
    localparam logic [1:0] CMD_LOAD_CACHE = 2'd0;
    localparam logic [1:0] CMD_LOAD_HOST  = 2'd1;
    localparam logic [1:0] CMD_EDGE       = 2'd2;
    localparam logic [1:0] CMD_ROW_END    = 2'd3;

    localparam logic [2:0] KIND_LOCAL  = 3'd0;
    localparam logic [2:0] KIND_CACHE  = 3'd1;
    localparam logic [2:0] KIND_HOST   = 3'd2;
    localparam logic [2:0] KIND_REMOTE = 3'd3;
    localparam logic [2:0] KIND_ROW    = 3'd4;

    localparam logic [1:0] MODE_LR     = 2'd0;
    localparam logic [1:0] MODE_LCR    = 2'd1;
    localparam logic [1:0] MODE_LCHR   = 2'd2;
    localparam logic [1:0] MODE_MERGED = 2'd3;

    localparam logic [1:0] REG_LOWER = 2'd0;
    localparam logic [1:0] REG_UPPER = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] node_id;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] neighbor;
        logic [31:0] local_count;
        logic [31:0] cache_count;
        logic [31:0] host_count;
        logic [31:0] remote_count;
    } t_out_word;
endpackage

/* rtl/core/cnps_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cnps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/cnps_front.sv */
// Front end: accepts words and pushes them into a two-entry queue.
// Depends on cnps_pkg.
`timescale 1ns / 1ps
module cnps_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  cnps_pkg::t_in_word i_word,
    input  logic              i_pop,
    output logic              o_valid,
    output cnps_pkg::t_in_word o_word
);
    import cnps_pkg::*;

    t_in_word   r_q [2];
    logic [1:0] r_cnt;
    logic       push;

    // accept only while the queue has room
    assign o_busy  = (r_cnt == 2'd2);
    assign push    = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q[0];

    // shift queue: head at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
        if (i_pop) begin
            r_q[0] <= (push && r_cnt == 2'd1) ? i_word : r_q[1];
        end else if (push) begin
            if (r_cnt[0]) begin
                r_q[1] <= i_word;
            end else begin
                r_q[0] <= i_word;
            end
        end
    end
endmodule

/* rtl/core/cnps_back.sv */
// Back end: table loads, binary searches, counts and result generation.
// Depends on cnps_pkg and cnps_ram.
`timescale 1ns / 1ps
module cnps_back #(
    parameter int CACHE_DEPTH = 4096,
    parameter int HOST_DEPTH  = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  cnps_pkg::t_in_word i_word,
    output logic               o_pop,
    input  logic [31:0]        i_lower,
    input  logic [31:0]        i_upper,
    input  logic [1:0]         i_mode,
    output logic               o_strobe,
    output cnps_pkg::t_out_word o_result
);
    import cnps_pkg::*;

    localparam int CAW = $clog2(CACHE_DEPTH > 1 ? CACHE_DEPTH : 2);
    localparam int HAW = $clog2(HOST_DEPTH > 1 ? HOST_DEPTH : 2);
    localparam int LW  = $clog2(CACHE_DEPTH > HOST_DEPTH ? CACHE_DEPTH + 1 : HOST_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_WAITC = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [LW-1:0] r_clen, r_hlen, r_lo, r_hi, n_lo, n_hi;
    logic        r_host;
    logic [31:0] r_id;
    logic [31:0] r_local, r_cache, r_host_cnt, r_remote;
    logic [LW-1:0] mid, len;
    logic [31:0] crd, hrd, rd;
    logic [CAW-1:0] c_raddr;
    logic [HAW-1:0] h_raddr;
    logic        c_we, h_we, is_local, hit;
    logic        go_host, n_strobe;
    logic [2:0]  kind;

    assign len = r_host ? r_hlen : r_clen;
    assign mid = r_lo + ((r_hi - r_lo) >> 1);
    assign rd  = r_host ? hrd : crd;
    assign is_local = (i_lower <= i_word.node_id) && (i_word.node_id < i_upper);

    // read address: midpoint while probing, low bound on final check
    always_comb begin
        c_raddr = r_state == S_CHECK ? r_lo[CAW-1:0] : mid[CAW-1:0];
        h_raddr = r_state == S_CHECK ? r_lo[HAW-1:0] : mid[HAW-1:0];
    end

    assign c_we = i_valid && r_state == S_IDLE && i_word.cmd == CMD_LOAD_CACHE
                  && r_clen < LW'(CACHE_DEPTH);
    assign h_we = i_valid && r_state == S_IDLE && i_word.cmd == CMD_LOAD_HOST
                  && r_hlen < LW'(HOST_DEPTH);

    cnps_ram #(.WIDTH(32), .DEPTH(CACHE_DEPTH)) u_cache (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(r_clen[CAW-1:0]),
        .i_wdata(i_word.node_id), .i_raddr(c_raddr), .o_rdata(crd));
    cnps_ram #(.WIDTH(32), .DEPTH(HOST_DEPTH)) u_hostt (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(r_hlen[HAW-1:0]),
        .i_wdata(i_word.node_id), .i_raddr(h_raddr), .o_rdata(hrd));

    // search step next values
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (rd < r_id) begin
            n_lo = mid + LW'(1);
        end else begin
            n_hi = mid;
        end
    end

    assign hit = (r_lo < len) && (rd == r_id);
    assign o_pop = (r_state == S_IDLE && i_valid &&
                    (i_word.cmd != CMD_EDGE || is_local || i_mode == MODE_LR))
                   || r_state == S_DONE;

    // class of a finished search, and whether to go on to the host table
    assign kind = !hit ? KIND_REMOTE
                : r_host ? KIND_HOST
                : (i_mode == MODE_MERGED ? KIND_LOCAL : KIND_CACHE);
    assign go_host = !hit && !r_host && i_mode == MODE_LCHR;

    // strobe on row ends, direct edges and finished searches
    always_comb begin
        n_strobe = 1'b0;
        if (r_state == S_IDLE && i_valid) begin
            n_strobe = (i_word.cmd == CMD_ROW_END)
                    || (i_word.cmd == CMD_EDGE && (is_local || i_mode == MODE_LR));
        end else if (r_state == S_WAITC) begin
            n_strobe = !go_host;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= n_strobe;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clen <= '0; r_hlen <= '0;
            r_local <= '0; r_cache <= '0; r_host_cnt <= '0; r_remote <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        unique case (i_word.cmd)
                            CMD_LOAD_CACHE: if (c_we) r_clen <= r_clen + LW'(1);
                            CMD_LOAD_HOST:  if (h_we) r_hlen <= r_hlen + LW'(1);
                            CMD_ROW_END: begin
                                o_result <= '{KIND_ROW, 32'd0, r_local, r_cache,
                                              r_host_cnt, r_remote};
                            end
                            default: begin
                                r_id <= i_word.node_id;
                                if (is_local) begin
                                    o_result <= '{KIND_LOCAL, i_word.node_id,
                                                  32'd0, 32'd0, 32'd0, 32'd0};
                                    if (~&r_local) r_local <= r_local + 32'd1;
                                end else if (i_mode == MODE_LR) begin
                                    o_result <= '{KIND_REMOTE, i_word.node_id,
                                                  32'd0, 32'd0, 32'd0, 32'd0};
                                    if (~&r_remote) r_remote <= r_remote + 32'd1;
                                end else begin
                                    r_host  <= 1'b0;
                                    r_lo    <= '0;
                                    r_hi    <= r_clen;
                                    r_state <= S_PROBE;
                                end
                            end
                        endcase
                    end
                end
                S_PROBE: r_state <= (r_lo < r_hi) ? S_WAIT : S_CHECK;
                S_WAIT: begin
                    r_lo <= n_lo;
                    r_hi <= n_hi;
                    r_state <= S_PROBE;
                end
                S_CHECK: r_state <= S_WAITC;
                S_WAITC: begin
                    if (go_host) begin
                        r_host  <= 1'b1;
                        r_lo    <= '0;
                        r_hi    <= r_hlen;
                        r_state <= S_PROBE;
                    end else begin
                        o_result <= '{kind, r_id, 32'd0, 32'd0, 32'd0, 32'd0};
                        unique case (kind)
                            KIND_LOCAL: if (~&r_local) r_local <= r_local + 32'd1;
                            KIND_CACHE: if (~&r_cache) r_cache <= r_cache + 32'd1;
                            KIND_HOST:  if (~&r_host_cnt) r_host_cnt <= r_host_cnt + 32'd1;
                            default:    if (~&r_remote) r_remote <= r_remote + 32'd1;
                        endcase
                        r_state <= S_DONE;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/core/csr_neighbor_partition_splitter_top.sv */
// Top level of the CSR neighbor partition splitter: config registers, front, back.
// Depends on cnps_pkg, cnps_front, cnps_back, cnps_ram.
//
//  channel | handshake           | payload
//  input   | start / busy        | i_word (cmd, node_id)
//  result  | o_strobe            | o_result (kind, neighbor, four counts)
//  config  | i_cfg_we            | i_cfg_index, i_cfg_data
//
// Loads, row ends and local or mode-0 edges are handled in the back end's idle state;
// a result word passes the queue and the registered result before it is strobed.
// Other edges binary-search the cache table, then the host table in mode 2: a table of
// length len takes at most k = floor(log2(len))+1 probes, each setting the midpoint
// address and then comparing; a final check reads the low bound before the pop.
// Reset is synchronous and clears lengths and counts; table contents stay undefined.
// The receiver cannot stall; busy is high only while the two-word queue is full.
`timescale 1ns / 1ps
module csr_neighbor_partition_splitter_top #(
    parameter int CACHE_DEPTH = 4096,
    parameter int HOST_DEPTH  = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  cnps_pkg::t_in_word  i_word,
    output logic                o_strobe,
    output cnps_pkg::t_out_word o_result,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import cnps_pkg::*;

    logic [31:0] r_lower, r_upper;
    logic [1:0]  r_mode;
    logic        q_valid, q_pop;
    t_in_word    q_word;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0; r_upper <= '0; r_mode <= MODE_LR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOWER: r_lower <= i_cfg_data;
                REG_UPPER: r_upper <= i_cfg_data;
                REG_MODE:  r_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    cnps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_word(i_word), .i_pop(q_pop), .o_valid(q_valid), .o_word(q_word));

    cnps_back #(.CACHE_DEPTH(CACHE_DEPTH), .HOST_DEPTH(HOST_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_word(q_word),
        .o_pop(q_pop), .i_lower(r_lower), .i_upper(r_upper), .i_mode(r_mode),
        .o_strobe(o_strobe), .o_result(o_result));
endmodule

/* rtl/core/cnps_checker.sv */
// Port-level checker for the splitter top level, bound to it below.
// Depends on cnps_pkg.
`timescale 1ns / 1ps
module cnps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_strobe,
    input cnps_pkg::t_out_word o_result
);
    import cnps_pkg::*;

    // kind stays in its range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.kind <= KIND_ROW) else $error("bad kind");
    // edge results carry zero local and remote counts
    a_edge0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind != KIND_ROW |-> o_result.local_count == 32'd0
        && o_result.remote_count == 32'd0) else $error("edge counts");
    // row results carry zero neighbor
    a_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == KIND_ROW |-> o_result.neighbor == 32'd0)
        else $error("row neighbor");
    // no strobe right after reset release
    a_rst: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_strobe) else $error("strobe in reset");
endmodule

bind csr_neighbor_partition_splitter_top cnps_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_strobe(o_strobe), .o_result(o_result));
